// ===== src/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

  localparam int unsigned ARENA_BYTES = 4096;
  localparam int unsigned ADDR_W      = $clog2(ARENA_BYTES);
  localparam int unsigned SIZE_W      = $clog2(ARENA_BYTES + 1);
  localparam int unsigned MIN_ARENA   = 16;

  localparam logic [31:0] END_MARK      = 32'hFFFF_FFFF;
  localparam logic [31:0] ALLOC_BIT     = 32'h8000_0000;
  localparam logic [31:0] HEAD_LINK     = 32'd4;
  localparam logic [31:0] FIRST_PAYLOAD = 32'd12;
  localparam logic [31:0] HDR_BYTES     = 32'd4;
  localparam logic [31:0] MIN_PAYLOAD   = 32'd4;
  localparam logic [31:0] MIN_SPLIT     = 32'd8;
  localparam logic [31:0] LINK_BYTES    = 32'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_FMT
  } mem_op_e;

  typedef enum logic [3:0] {
    AS_HEAD,
    AS_CUR,
    AS_CUR_HDR,
    AS_REST,
    AS_REST_LINK,
    AS_PREV,
    AS_PREV_HDR,
    AS_OFF,
    AS_OFF_HDR,
    AS_NB,
    AS_NB_LINK
  } addr_sel_e;

  typedef enum logic [2:0] {
    DS_REST_HDR,
    DS_WORD,
    DS_REST_LINK,
    DS_HDR_ALLOC,
    DS_HDR,
    DS_OFF,
    DS_PH_SUM,
    DS_SUCC
  } data_sel_e;

  typedef enum logic [2:0] {
    DST_CUR,
    DST_HDR,
    DST_WORD,
    DST_SUCC,
    DST_NBH,
    DST_PH
  } dst_e;

  typedef enum logic [5:0] {
    S_FMT,
    S_IDLE,
    S_A_HEAD,
    S_A_CHECK,
    S_A_HDR,
    S_A_TEST,
    S_A_NEXT,
    S_A_SPLIT_HDR,
    S_A_SPLIT_RD,
    S_A_SPLIT_LINK,
    S_A_SPLIT_PREV,
    S_A_TAKE_LINK,
    S_A_TAKE_PREV,
    S_A_MARK,
    S_F_CHECK,
    S_F_HDR,
    S_F_TEST,
    S_F_HEAD,
    S_F_WALK,
    S_F_NEXT,
    S_F_SUCC,
    S_F_CLR,
    S_F_NBH,
    S_F_MERGE_TEST,
    S_F_NB_LINK,
    S_F_NB_WR,
    S_F_SIZE,
    S_F_SUCC_LINK,
    S_F_PREV_TEST,
    S_F_HEAD_WR,
    S_F_PH,
    S_F_ADJ_TEST,
    S_F_PMERGE,
    S_F_PM_RD,
    S_F_PM_WR,
    S_F_PLINK,
    S_FIN_WHERE,
    S_FIN_OK,
    S_FIN_NOFIT,
    S_FIN_BAD
  } state_e;

  typedef struct packed {
    mem_op_e   op;
    addr_sel_e asel;
    data_sel_e dsel;
    dst_e      dst;
    logic      ld_in;
    logic      prev_head;
    logic      prev_cur;
    logic      steps_clr;
    logic      steps_inc;
    logic      hdr_need;
    logic      hdr_clr;
    logic      hdr_merge;
    logic      fin;
    status_e   fin_status;
    logic      fin_where;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mem_done;
    logic fmt_done;
    logic cur_link_ok;
    logic steps_max;
    logic hdr_fit;
    logic split_ok;
    logic off_bad;
    logic hdr_alloc;
    logic cur_lt_off;
    logic nb_merge;
    logic prev_is_head;
    logic ph_adj;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] fmt_byte(input logic [ADDR_W-1:0] a,
                                          input logic [SIZE_W-1:0] sz);
    logic [31:0] w;
    w = 32'd0;
    if (a[ADDR_W-1:2] == (ADDR_W-2)'(0)) begin
      w = 32'(sz);
    end else if (a[ADDR_W-1:2] == (ADDR_W-2)'(1)) begin
      w = FIRST_PAYLOAD;
    end else if (a[ADDR_W-1:2] == (ADDR_W-2)'(2)) begin
      w = 32'(sz) - MIN_SPLIT;
    end else if (a[ADDR_W-1:2] == (ADDR_W-2)'(3)) begin
      w = END_MARK;
    end
    return w[{a[1:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ===== src/first_fit_free_list_allocator.sv =====
// allocate walks the free list from the head link and takes the first free block that fits,
// whole or split; free rejects an offset outside the arena or a block not allocated, else
// walks the list to the insertion point, links the block in and merges it with free neighbours
// each arena word is written or read one byte at a time on the single byte-wide arena port
// one request in flight; the next is taken in the cycle after the result is registered
// reset and every arena_size write start a formatting sweep over all 4096 arena bytes; no request taken
`default_nettype none
module first_fit_free_list_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0] cfg_arena_size_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       mode_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0] request_size_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0] block_offset_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [ffa_pkg::ADDR_W-1:0]      payload_offset_o
);

  ffa_pkg::ctrl_cmd_t  cmd;
  ffa_pkg::dp_status_t dp_status;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (dp_status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ffa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_arena_size_i (cfg_arena_size_i),
    .request_size_i   (request_size_i),
    .block_offset_i   (block_offset_i),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .res_status_o     (status_o),
    .payload_offset_o (payload_offset_o)
  );

endmodule
`default_nettype wire

// ===== src/ffa_ctrl.sv =====
`default_nettype none
module ffa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               in_valid_i,
  input  wire logic               mode_i,
  input  wire ffa_pkg::dp_status_t status_i,
  output ffa_pkg::ctrl_cmd_t      cmd_o,
  output logic                    in_stall_o
);

  ffa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::S_FMT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::S_FMT: if (status_i.fmt_done) state_d = ffa_pkg::S_IDLE;
      ffa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mode_i ? ffa_pkg::S_F_CHECK : ffa_pkg::S_A_HEAD;
      end
      ffa_pkg::S_A_HEAD: if (status_i.mem_done) state_d = ffa_pkg::S_A_CHECK;
      ffa_pkg::S_A_CHECK: begin
        state_d = (!status_i.cur_link_ok || status_i.steps_max) ?
                  ffa_pkg::S_FIN_NOFIT : ffa_pkg::S_A_HDR;
      end
      ffa_pkg::S_A_HDR: if (status_i.mem_done) state_d = ffa_pkg::S_A_TEST;
      ffa_pkg::S_A_TEST: begin
        if (status_i.hdr_fit) begin
          state_d = status_i.split_ok ? ffa_pkg::S_A_SPLIT_HDR : ffa_pkg::S_A_TAKE_LINK;
        end else begin
          state_d = ffa_pkg::S_A_NEXT;
        end
      end
      ffa_pkg::S_A_NEXT: if (status_i.mem_done) state_d = ffa_pkg::S_A_CHECK;
      ffa_pkg::S_A_SPLIT_HDR: if (status_i.mem_done) state_d = ffa_pkg::S_A_SPLIT_RD;
      ffa_pkg::S_A_SPLIT_RD: if (status_i.mem_done) state_d = ffa_pkg::S_A_SPLIT_LINK;
      ffa_pkg::S_A_SPLIT_LINK: if (status_i.mem_done) state_d = ffa_pkg::S_A_SPLIT_PREV;
      ffa_pkg::S_A_SPLIT_PREV: if (status_i.mem_done) state_d = ffa_pkg::S_A_MARK;
      ffa_pkg::S_A_TAKE_LINK: if (status_i.mem_done) state_d = ffa_pkg::S_A_TAKE_PREV;
      ffa_pkg::S_A_TAKE_PREV: if (status_i.mem_done) state_d = ffa_pkg::S_A_MARK;
      ffa_pkg::S_A_MARK: if (status_i.mem_done) state_d = ffa_pkg::S_FIN_WHERE;
      ffa_pkg::S_F_CHECK: begin
        state_d = status_i.off_bad ? ffa_pkg::S_FIN_BAD : ffa_pkg::S_F_HDR;
      end
      ffa_pkg::S_F_HDR: if (status_i.mem_done) state_d = ffa_pkg::S_F_TEST;
      ffa_pkg::S_F_TEST: begin
        state_d = status_i.hdr_alloc ? ffa_pkg::S_F_HEAD : ffa_pkg::S_FIN_BAD;
      end
      ffa_pkg::S_F_HEAD: if (status_i.mem_done) state_d = ffa_pkg::S_F_WALK;
      ffa_pkg::S_F_WALK: begin
        state_d = (status_i.cur_link_ok && status_i.cur_lt_off && !status_i.steps_max) ?
                  ffa_pkg::S_F_NEXT : ffa_pkg::S_F_SUCC;
      end
      ffa_pkg::S_F_NEXT: if (status_i.mem_done) state_d = ffa_pkg::S_F_WALK;
      ffa_pkg::S_F_SUCC: if (status_i.mem_done) state_d = ffa_pkg::S_F_CLR;
      ffa_pkg::S_F_CLR: if (status_i.mem_done) state_d = ffa_pkg::S_F_NBH;
      ffa_pkg::S_F_NBH: if (status_i.mem_done) state_d = ffa_pkg::S_F_MERGE_TEST;
      ffa_pkg::S_F_MERGE_TEST: begin
        state_d = status_i.nb_merge ? ffa_pkg::S_F_NB_LINK : ffa_pkg::S_F_SUCC_LINK;
      end
      ffa_pkg::S_F_NB_LINK: if (status_i.mem_done) state_d = ffa_pkg::S_F_NB_WR;
      ffa_pkg::S_F_NB_WR: if (status_i.mem_done) state_d = ffa_pkg::S_F_SIZE;
      ffa_pkg::S_F_SIZE: if (status_i.mem_done) state_d = ffa_pkg::S_F_PREV_TEST;
      ffa_pkg::S_F_SUCC_LINK: if (status_i.mem_done) state_d = ffa_pkg::S_F_PREV_TEST;
      ffa_pkg::S_F_PREV_TEST: begin
        state_d = status_i.prev_is_head ? ffa_pkg::S_F_HEAD_WR : ffa_pkg::S_F_PH;
      end
      ffa_pkg::S_F_HEAD_WR: if (status_i.mem_done) state_d = ffa_pkg::S_FIN_OK;
      ffa_pkg::S_F_PH: if (status_i.mem_done) state_d = ffa_pkg::S_F_ADJ_TEST;
      ffa_pkg::S_F_ADJ_TEST: begin
        state_d = status_i.ph_adj ? ffa_pkg::S_F_PMERGE : ffa_pkg::S_F_PLINK;
      end
      ffa_pkg::S_F_PMERGE: if (status_i.mem_done) state_d = ffa_pkg::S_F_PM_RD;
      ffa_pkg::S_F_PM_RD: if (status_i.mem_done) state_d = ffa_pkg::S_F_PM_WR;
      ffa_pkg::S_F_PM_WR: if (status_i.mem_done) state_d = ffa_pkg::S_FIN_OK;
      ffa_pkg::S_F_PLINK: if (status_i.mem_done) state_d = ffa_pkg::S_FIN_OK;
      ffa_pkg::S_FIN_WHERE, ffa_pkg::S_FIN_OK, ffa_pkg::S_FIN_NOFIT,
      ffa_pkg::S_FIN_BAD: begin
        if (status_i.out_free) state_d = ffa_pkg::S_IDLE;
      end
      default: state_d = ffa_pkg::S_FMT;
    endcase
    if (cfg_we_i) state_d = ffa_pkg::S_FMT;
  end

  // outputs
  always_comb begin
    cmd_o.op         = ffa_pkg::OP_NONE;
    cmd_o.asel       = ffa_pkg::AS_HEAD;
    cmd_o.dsel       = ffa_pkg::DS_WORD;
    cmd_o.dst        = ffa_pkg::DST_WORD;
    cmd_o.ld_in      = 1'b0;
    cmd_o.prev_head  = 1'b0;
    cmd_o.prev_cur   = 1'b0;
    cmd_o.steps_clr  = 1'b0;
    cmd_o.steps_inc  = 1'b0;
    cmd_o.hdr_need   = 1'b0;
    cmd_o.hdr_clr    = 1'b0;
    cmd_o.hdr_merge  = 1'b0;
    cmd_o.fin        = 1'b0;
    cmd_o.fin_status = ffa_pkg::ST_OK;
    cmd_o.fin_where  = 1'b0;
    in_stall_o       = 1'b1;
    case (state_q)
      ffa_pkg::S_FMT: cmd_o.op = ffa_pkg::OP_FMT;
      ffa_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.ld_in = in_valid_i;
      end
      ffa_pkg::S_A_HEAD, ffa_pkg::S_F_HEAD: begin
        cmd_o.op        = ffa_pkg::OP_READ;
        cmd_o.asel      = ffa_pkg::AS_HEAD;
        cmd_o.dst       = ffa_pkg::DST_CUR;
        cmd_o.prev_head = status_i.mem_done;
        cmd_o.steps_clr = status_i.mem_done;
      end
      ffa_pkg::S_A_HDR: begin
        cmd_o.op        = ffa_pkg::OP_READ;
        cmd_o.asel      = ffa_pkg::AS_CUR_HDR;
        cmd_o.dst       = ffa_pkg::DST_HDR;
        cmd_o.steps_inc = status_i.mem_done;
      end
      ffa_pkg::S_A_NEXT: begin
        cmd_o.op       = ffa_pkg::OP_READ;
        cmd_o.asel     = ffa_pkg::AS_CUR;
        cmd_o.dst      = ffa_pkg::DST_CUR;
        cmd_o.prev_cur = status_i.mem_done;
      end
      ffa_pkg::S_A_SPLIT_HDR: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_REST;
        cmd_o.dsel = ffa_pkg::DS_REST_HDR;
      end
      ffa_pkg::S_A_SPLIT_RD, ffa_pkg::S_A_TAKE_LINK: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_CUR;
        cmd_o.dst  = ffa_pkg::DST_WORD;
      end
      ffa_pkg::S_A_SPLIT_LINK: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_REST_LINK;
        cmd_o.dsel = ffa_pkg::DS_WORD;
      end
      ffa_pkg::S_A_SPLIT_PREV: begin
        cmd_o.op       = ffa_pkg::OP_WRITE;
        cmd_o.asel     = ffa_pkg::AS_PREV;
        cmd_o.dsel     = ffa_pkg::DS_REST_LINK;
        cmd_o.hdr_need = status_i.mem_done;
      end
      ffa_pkg::S_A_TAKE_PREV, ffa_pkg::S_F_PM_WR: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_PREV;
        cmd_o.dsel = ffa_pkg::DS_WORD;
      end
      ffa_pkg::S_A_MARK: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_CUR_HDR;
        cmd_o.dsel = ffa_pkg::DS_HDR_ALLOC;
      end
      ffa_pkg::S_F_HDR: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_OFF_HDR;
        cmd_o.dst  = ffa_pkg::DST_HDR;
      end
      ffa_pkg::S_F_NEXT: begin
        cmd_o.op        = ffa_pkg::OP_READ;
        cmd_o.asel      = ffa_pkg::AS_CUR;
        cmd_o.dst       = ffa_pkg::DST_CUR;
        cmd_o.prev_cur  = status_i.mem_done;
        cmd_o.steps_inc = status_i.mem_done;
      end
      ffa_pkg::S_F_SUCC: begin
        cmd_o.op      = ffa_pkg::OP_READ;
        cmd_o.asel    = ffa_pkg::AS_PREV;
        cmd_o.dst     = ffa_pkg::DST_SUCC;
        cmd_o.hdr_clr = status_i.mem_done;
      end
      ffa_pkg::S_F_CLR, ffa_pkg::S_F_SIZE: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_OFF_HDR;
        cmd_o.dsel = ffa_pkg::DS_HDR;
      end
      ffa_pkg::S_F_NBH: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_NB;
        cmd_o.dst  = ffa_pkg::DST_NBH;
      end
      ffa_pkg::S_F_NB_LINK: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_NB_LINK;
        cmd_o.dst  = ffa_pkg::DST_WORD;
      end
      ffa_pkg::S_F_NB_WR: begin
        cmd_o.op        = ffa_pkg::OP_WRITE;
        cmd_o.asel      = ffa_pkg::AS_OFF;
        cmd_o.dsel      = ffa_pkg::DS_WORD;
        cmd_o.hdr_merge = status_i.mem_done;
      end
      ffa_pkg::S_F_SUCC_LINK: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_OFF;
        cmd_o.dsel = ffa_pkg::DS_SUCC;
      end
      ffa_pkg::S_F_HEAD_WR: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_HEAD;
        cmd_o.dsel = ffa_pkg::DS_OFF;
      end
      ffa_pkg::S_F_PH: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_PREV_HDR;
        cmd_o.dst  = ffa_pkg::DST_PH;
      end
      ffa_pkg::S_F_PMERGE: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_PREV_HDR;
        cmd_o.dsel = ffa_pkg::DS_PH_SUM;
      end
      ffa_pkg::S_F_PM_RD: begin
        cmd_o.op   = ffa_pkg::OP_READ;
        cmd_o.asel = ffa_pkg::AS_OFF;
        cmd_o.dst  = ffa_pkg::DST_WORD;
      end
      ffa_pkg::S_F_PLINK: begin
        cmd_o.op   = ffa_pkg::OP_WRITE;
        cmd_o.asel = ffa_pkg::AS_PREV;
        cmd_o.dsel = ffa_pkg::DS_OFF;
      end
      ffa_pkg::S_FIN_WHERE: begin
        cmd_o.fin       = status_i.out_free;
        cmd_o.fin_where = 1'b1;
      end
      ffa_pkg::S_FIN_OK: cmd_o.fin = status_i.out_free;
      ffa_pkg::S_FIN_NOFIT: begin
        cmd_o.fin        = status_i.out_free;
        cmd_o.fin_status = ffa_pkg::ST_NO_FIT;
      end
      ffa_pkg::S_FIN_BAD: begin
        cmd_o.fin        = status_i.out_free;
        cmd_o.fin_status = ffa_pkg::ST_NOT_ALLOC;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ffa_dp.sv =====
`default_nettype none
module ffa_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    cfg_arena_size_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    request_size_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0]    block_offset_i,
  input  wire ffa_pkg::ctrl_cmd_t            cmd_i,
  output ffa_pkg::dp_status_t                status_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [1:0]                         res_status_o,
  output logic [ffa_pkg::ADDR_W-1:0]         payload_offset_o
);

  logic [7:0]                   mem_q [ffa_pkg::ARENA_BYTES];
  logic [7:0]                   rdata_q;
  logic                         rd_ok_q;
  logic [2:0]                   cnt_q;
  logic [ffa_pkg::ADDR_W-1:0]   fcnt_q;
  logic [ffa_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [ffa_pkg::SIZE_W-1:0]   req_q;
  logic [ffa_pkg::ADDR_W-1:0]   off_q;
  logic [31:0]                  cur_q, prev_q, hdr_q, succ_q, nbh_q, ph_q, word_q;
  logic [23:0]                  acc_q;
  logic [ffa_pkg::SIZE_W-1:0]   steps_q;
  logic                         out_valid_q;
  ffa_pkg::status_e             res_status_q;
  logic [ffa_pkg::ADDR_W-1:0]   res_off_q;

  logic [31:0] size32, off32, pay, need, rest, nb, base, wdata, baddr, rword;
  logic [7:0]  rbyte, mem_wd;
  logic [ffa_pkg::ADDR_W-1:0] mem_a;
  logic        in_rng, mem_we, rd_done, wr_done, busy_rd, busy_wr;

  assign size32 = 32'(size_q);
  assign off32  = 32'(off_q);
  assign pay    = (32'(req_q) < ffa_pkg::MIN_PAYLOAD) ? ffa_pkg::MIN_PAYLOAD : 32'(req_q);
  assign need   = pay + ffa_pkg::HDR_BYTES;
  assign rest   = cur_q + pay;
  assign nb     = off32 - ffa_pkg::HDR_BYTES + hdr_q;

  always_comb begin
    case (cmd_i.asel)
      ffa_pkg::AS_HEAD:      base = ffa_pkg::HEAD_LINK;
      ffa_pkg::AS_CUR:       base = cur_q;
      ffa_pkg::AS_CUR_HDR:   base = cur_q - ffa_pkg::HDR_BYTES;
      ffa_pkg::AS_REST:      base = rest;
      ffa_pkg::AS_REST_LINK: base = rest + ffa_pkg::HDR_BYTES;
      ffa_pkg::AS_PREV:      base = prev_q;
      ffa_pkg::AS_PREV_HDR:  base = prev_q - ffa_pkg::HDR_BYTES;
      ffa_pkg::AS_OFF:       base = off32;
      ffa_pkg::AS_OFF_HDR:   base = off32 - ffa_pkg::HDR_BYTES;
      ffa_pkg::AS_NB:        base = nb;
      ffa_pkg::AS_NB_LINK:   base = nb + ffa_pkg::HDR_BYTES;
      default:               base = ffa_pkg::HEAD_LINK;
    endcase
  end

  always_comb begin
    case (cmd_i.dsel)
      ffa_pkg::DS_REST_HDR:  wdata = hdr_q - need;
      ffa_pkg::DS_WORD:      wdata = word_q;
      ffa_pkg::DS_REST_LINK: wdata = rest + ffa_pkg::HDR_BYTES;
      ffa_pkg::DS_HDR_ALLOC: wdata = hdr_q | ffa_pkg::ALLOC_BIT;
      ffa_pkg::DS_HDR:       wdata = hdr_q;
      ffa_pkg::DS_OFF:       wdata = off32;
      ffa_pkg::DS_PH_SUM:    wdata = ph_q + hdr_q;
      ffa_pkg::DS_SUCC:      wdata = succ_q;
      default:               wdata = hdr_q;
    endcase
  end

  // byte sequencer over the single arena port
  assign busy_rd = (cmd_i.op == ffa_pkg::OP_READ);
  assign busy_wr = (cmd_i.op == ffa_pkg::OP_WRITE);
  assign baddr   = base + 32'(cnt_q[1:0]);
  assign in_rng  = (baddr < 32'(ffa_pkg::ARENA_BYTES));
  assign rd_done = busy_rd && (cnt_q == 3'd4);
  assign wr_done = busy_wr && (cnt_q == 3'd3);
  assign rbyte   = rd_ok_q ? rdata_q : 8'h00;
  assign rword   = {rbyte, acc_q};

  always_comb begin
    mem_we = 1'b0;
    mem_a  = baddr[ffa_pkg::ADDR_W-1:0];
    mem_wd = wdata[{cnt_q[1:0], 3'b000} +: 8];
    if (cmd_i.op == ffa_pkg::OP_FMT) begin
      mem_we = 1'b1;
      mem_a  = fcnt_q;
      mem_wd = ffa_pkg::fmt_byte(fcnt_q, size_q);
    end else if (busy_wr) begin
      mem_we = in_rng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_a] <= mem_wd;
    rdata_q <= mem_q[mem_a];
    rd_ok_q <= in_rng;
  end

  always_comb begin
    size_d = cfg_arena_size_i;
    if (cfg_arena_size_i < ffa_pkg::SIZE_W'(ffa_pkg::MIN_ARENA)) begin
      size_d = ffa_pkg::SIZE_W'(ffa_pkg::MIN_ARENA);
    end else if (cfg_arena_size_i > ffa_pkg::SIZE_W'(ffa_pkg::ARENA_BYTES)) begin
      size_d = ffa_pkg::SIZE_W'(ffa_pkg::ARENA_BYTES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 3'd0;
      fcnt_q      <= '0;
      size_q      <= ffa_pkg::SIZE_W'(ffa_pkg::ARENA_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      if ((busy_rd || busy_wr) && !rd_done && !wr_done) begin
        cnt_q <= cnt_q + 3'd1;
      end else begin
        cnt_q <= 3'd0;
      end
      if (cfg_we_i || cmd_i.op != ffa_pkg::OP_FMT) begin
        fcnt_q <= '0;
      end else begin
        fcnt_q <= fcnt_q + ffa_pkg::ADDR_W'(1);
      end
      if (cfg_we_i) size_q <= size_d;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_rd && cnt_q != 3'd0 && cnt_q != 3'd4) begin
      acc_q[{cnt_q[1:0] - 2'd1, 3'b000} +: 8] <= rbyte;
    end
    if (rd_done) begin
      case (cmd_i.dst)
        ffa_pkg::DST_CUR:  cur_q  <= rword;
        ffa_pkg::DST_HDR:  hdr_q  <= rword;
        ffa_pkg::DST_WORD: word_q <= rword;
        ffa_pkg::DST_SUCC: succ_q <= rword;
        ffa_pkg::DST_NBH:  nbh_q  <= rword;
        ffa_pkg::DST_PH:   ph_q   <= rword;
        default: ;
      endcase
    end
    if (cmd_i.ld_in) begin
      req_q <= request_size_i;
      off_q <= block_offset_i;
    end
    if (cmd_i.prev_head) prev_q <= ffa_pkg::HEAD_LINK;
    if (cmd_i.prev_cur) prev_q <= cur_q;
    if (cmd_i.steps_clr) begin
      steps_q <= '0;
    end else if (cmd_i.steps_inc) begin
      steps_q <= steps_q + ffa_pkg::SIZE_W'(1);
    end
    if (cmd_i.hdr_need) hdr_q <= need;
    if (cmd_i.hdr_clr) hdr_q <= hdr_q & ~ffa_pkg::ALLOC_BIT;
    if (cmd_i.hdr_merge) hdr_q <= hdr_q + nbh_q;
    if (cmd_i.fin) begin
      res_status_q <= cmd_i.fin_status;
      res_off_q    <= cmd_i.fin_where ? cur_q[ffa_pkg::ADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    status_o.mem_done     = rd_done || wr_done;
    status_o.fmt_done     = (cmd_i.op == ffa_pkg::OP_FMT) && (fcnt_q == '1) && !cfg_we_i;
    status_o.cur_link_ok  = (cur_q != ffa_pkg::END_MARK) && (cur_q >= ffa_pkg::FIRST_PAYLOAD)
                            && (cur_q + ffa_pkg::LINK_BYTES <= size32);
    status_o.steps_max    = (steps_q == ffa_pkg::SIZE_W'(ffa_pkg::ARENA_BYTES));
    status_o.hdr_fit      = !hdr_q[31] && (hdr_q >= need);
    status_o.split_ok     = ((hdr_q - need) >= ffa_pkg::MIN_SPLIT) && (cur_q + need <= size32);
    status_o.off_bad      = (off32 < ffa_pkg::FIRST_PAYLOAD)
                            || (off32 + ffa_pkg::LINK_BYTES > size32);
    status_o.hdr_alloc    = hdr_q[31];
    status_o.cur_lt_off   = (cur_q < off32);
    status_o.nb_merge     = (nbh_q != 32'd0) && !nbh_q[31]
                            && (nb + ffa_pkg::MIN_SPLIT <= size32);
    status_o.prev_is_head = (prev_q == ffa_pkg::HEAD_LINK);
    status_o.ph_adj       = (prev_q - ffa_pkg::HDR_BYTES + ph_q)
                            == (off32 - ffa_pkg::HDR_BYTES);
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign res_status_o     = res_status_q;
  assign payload_offset_o = res_off_q;

endmodule
`default_nettype wire

// ===== tb/ffa_checker.sv =====
`default_nettype none
module ffa_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0] cfg_arena_size_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire logic                       mode_i,
  input  wire logic [ffa_pkg::SIZE_W-1:0] request_size_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0] block_offset_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire logic [1:0]                 status_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0] payload_offset_i,
  output int                              errors_o,
  output int                              pending_o
);

  typedef struct packed {
    ffa_pkg::status_e           st;
    logic [ffa_pkg::ADDR_W-1:0] where;
  } alloc_result_t;

  logic [7:0]    arena_mem [ffa_pkg::ARENA_BYTES];
  logic [31:0]   arena_len;
  alloc_result_t result_q[$];

  function automatic logic [31:0] mem_rd(input logic [31:0] o);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      if (o + 32'(i) < 32'(ffa_pkg::ARENA_BYTES)) begin
        v[8*i +: 8] = arena_mem[ffa_pkg::ADDR_W'(o + 32'(i))];
      end
    end
    return v;
  endfunction

  function automatic void mem_wr(input logic [31:0] o, input logic [31:0] v);
    for (int i = 0; i < 4; i++) begin
      if (o + 32'(i) < 32'(ffa_pkg::ARENA_BYTES)) begin
        arena_mem[ffa_pkg::ADDR_W'(o + 32'(i))] = v[8*i +: 8];
      end
    end
  endfunction

  function automatic bit link_valid(input logic [31:0] p);
    return p != ffa_pkg::END_MARK && p >= ffa_pkg::FIRST_PAYLOAD
           && p + ffa_pkg::LINK_BYTES <= arena_len;
  endfunction

  function automatic void reformat(input logic [31:0] sz);
    if (sz < ffa_pkg::MIN_ARENA) sz = ffa_pkg::MIN_ARENA;
    if (sz > ffa_pkg::ARENA_BYTES) sz = ffa_pkg::ARENA_BYTES;
    arena_len = sz;
    for (int i = 0; i < ffa_pkg::ARENA_BYTES; i++) arena_mem[ffa_pkg::ADDR_W'(i)] = '0;
    mem_wr(0, arena_len);
    mem_wr(ffa_pkg::HEAD_LINK, ffa_pkg::FIRST_PAYLOAD);
    mem_wr(ffa_pkg::FIRST_PAYLOAD - ffa_pkg::HDR_BYTES, arena_len - ffa_pkg::MIN_SPLIT);
    mem_wr(ffa_pkg::FIRST_PAYLOAD, ffa_pkg::END_MARK);
  endfunction

  function automatic alloc_result_t first_fit(input logic [31:0] req);
    logic [31:0]   sz, need, prev, cur, hdr, rest, steps;
    alloc_result_t r;
    sz    = req < ffa_pkg::MIN_PAYLOAD ? ffa_pkg::MIN_PAYLOAD : req;
    need  = sz + ffa_pkg::HDR_BYTES;
    prev  = ffa_pkg::HEAD_LINK;
    cur   = mem_rd(ffa_pkg::HEAD_LINK);
    steps = 0;
    r.st    = ffa_pkg::ST_NO_FIT;
    r.where = '0;
    while (link_valid(cur) && steps < ffa_pkg::ARENA_BYTES) begin
      hdr = mem_rd(cur - ffa_pkg::HDR_BYTES);
      steps++;
      if ((hdr & ffa_pkg::ALLOC_BIT) == 0 && hdr >= need) begin
        if (hdr - need >= ffa_pkg::MIN_SPLIT && cur + need <= arena_len) begin
          rest = cur + sz;
          mem_wr(rest, hdr - need);
          mem_wr(rest + ffa_pkg::HDR_BYTES, mem_rd(cur));
          mem_wr(prev, rest + ffa_pkg::HDR_BYTES);
          hdr = need;
        end else begin
          mem_wr(prev, mem_rd(cur));
        end
        mem_wr(cur - ffa_pkg::HDR_BYTES, hdr | ffa_pkg::ALLOC_BIT);
        r.st    = ffa_pkg::ST_OK;
        r.where = cur[ffa_pkg::ADDR_W-1:0];
        return r;
      end
      prev = cur;
      cur  = mem_rd(cur);
    end
    return r;
  endfunction

  function automatic ffa_pkg::status_e release_block(input logic [31:0] off);
    logic [31:0] hdr, prev, cur, succ, nb, nbh, ph, steps;
    if (off < ffa_pkg::FIRST_PAYLOAD || off + ffa_pkg::LINK_BYTES > arena_len) begin
      return ffa_pkg::ST_NOT_ALLOC;
    end
    hdr = mem_rd(off - ffa_pkg::HDR_BYTES);
    if ((hdr & ffa_pkg::ALLOC_BIT) == 0) return ffa_pkg::ST_NOT_ALLOC;
    prev  = ffa_pkg::HEAD_LINK;
    cur   = mem_rd(ffa_pkg::HEAD_LINK);
    steps = 0;
    while (link_valid(cur) && cur < off && steps < ffa_pkg::ARENA_BYTES) begin
      steps++;
      prev = cur;
      cur  = mem_rd(cur);
    end
    succ = mem_rd(prev);
    hdr  = hdr & ~ffa_pkg::ALLOC_BIT;
    mem_wr(off - ffa_pkg::HDR_BYTES, hdr);
    nb  = off - ffa_pkg::HDR_BYTES + hdr;
    nbh = mem_rd(nb);
    if (nbh != 0 && (nbh & ffa_pkg::ALLOC_BIT) == 0 && nb + 8 <= arena_len) begin
      mem_wr(off, mem_rd(nb + ffa_pkg::HDR_BYTES));
      hdr = hdr + nbh;
      mem_wr(off - ffa_pkg::HDR_BYTES, hdr);
    end else begin
      mem_wr(off, succ);
    end
    if (prev == ffa_pkg::HEAD_LINK) begin
      mem_wr(ffa_pkg::HEAD_LINK, off);
    end else begin
      ph = mem_rd(prev - ffa_pkg::HDR_BYTES);
      if (prev - ffa_pkg::HDR_BYTES + ph == off - ffa_pkg::HDR_BYTES) begin
        mem_wr(prev - ffa_pkg::HDR_BYTES, ph + hdr);
        mem_wr(prev, mem_rd(off));
      end else begin
        mem_wr(prev, off);
      end
    end
    return ffa_pkg::ST_OK;
  endfunction

  assign pending_o = result_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t r, e;
    if (!rst_ni) begin
      reformat(ffa_pkg::ARENA_BYTES);
      result_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i) reformat(32'(cfg_arena_size_i));
      if (in_valid_i && !in_stall_i) begin
        if (!mode_i) begin
          r = first_fit(32'(request_size_i));
        end else begin
          r.st    = release_block(32'(block_offset_i));
          r.where = '0;
        end
        result_q.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status %0d offset %0d", $time, status_i,
                   payload_offset_i);
          errors_o <= errors_o + 1;
        end else begin
          e = result_q.pop_front();
          if (status_i !== e.st || payload_offset_i !== e.where) begin
            $display("%0t: expected status %0d offset %0d, got status %0d offset %0d",
                     $time, e.st, e.where, status_i, payload_offset_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_first_fit_free_list_allocator.sv =====
`default_nettype none
module tb_first_fit_free_list_allocator;

  localparam int unsigned CYCLE_LIMIT = 30_000_000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [ffa_pkg::SIZE_W-1:0] cfg_arena_size_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i = 1'b0;
  logic [ffa_pkg::SIZE_W-1:0] request_size_i = '0;
  logic [ffa_pkg::ADDR_W-1:0] block_offset_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 status_o;
  logic [ffa_pkg::ADDR_W-1:0] payload_offset_o;

  int          errors, pending;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  logic        mode_q[$];
  logic [ffa_pkg::ADDR_W-1:0] live_q[$];
  logic [ffa_pkg::ADDR_W-1:0] freed_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_free_list_allocator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_arena_size_i, .in_valid_i, .in_stall_o,
    .mode_i, .request_size_i, .block_offset_i, .out_valid_o, .out_stall_i,
    .status_o, .payload_offset_o
  );

  ffa_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_arena_size_i, .in_valid_i,
    .in_stall_i(in_stall_o), .mode_i, .request_size_i, .block_offset_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .payload_offset_i(payload_offset_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure and tracking of handed-out blocks
  always @(posedge clk_i) begin
    int unsigned nxt;
    logic        m;
    nxt = stall_left > 0 ? stall_left - 1 : 0;
    if (out_valid_o && !out_stall_i) begin
      nxt = quiet ? 0 : $urandom_range(0, 12);
      m = mode_q.size() ? mode_q.pop_front() : 1'b1;
      if (!m && status_o == ffa_pkg::ST_OK) live_q.push_back(payload_offset_o);
    end
    stall_left  <= nxt;
    out_stall_i <= rst_ni && nxt != 0;
  end

  task automatic send(input logic m, input int unsigned req, input int unsigned off);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    request_size_i <= ffa_pkg::SIZE_W'(req);
    block_offset_i <= ffa_pkg::ADDR_W'(off);
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    mode_q.push_back(m);
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || mode_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_arena(input int unsigned sz);
    drain();
    cfg_we_i         <= 1'b1;
    cfg_arena_size_i <= ffa_pkg::SIZE_W'(sz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_q.delete();
    freed_q.delete();
  endtask

  task automatic free_live(input int unsigned idx);
    logic [ffa_pkg::ADDR_W-1:0] o;
    o = live_q[idx];
    live_q.delete(idx);
    freed_q.push_back(o);
    if (freed_q.size() > 8) void'(freed_q.pop_front());
    send(1'b1, $urandom_range(0, 4096), o);
  endtask

  task automatic random_items(input int unsigned n, input int unsigned big_pct);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      while (live_q.size() == 0 && mode_q.size() != 0 && r >= 55 && r < 90) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      if (r < 55 || (r < 90 && live_q.size() == 0)) begin
        send(1'b0, $urandom_range(0, 99) < big_pct ? $urandom_range(0, 4096)
                                                    : $urandom_range(0, 48),
             $urandom_range(0, 4095));
      end else if (r < 90) begin
        free_live($urandom_range(0, live_q.size() - 1));
      end else if (r < 95 && freed_q.size() != 0) begin
        send(1'b1, $urandom_range(0, 4096), freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else begin
        send(1'b1, $urandom_range(0, 4096), $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, exact fit, double free, merges, bad offsets
    send(1'b0, 4096, 0);
    send(1'b0, 4084, 4095);
    send(1'b0, 0, 0);
    send(1'b0, 4, 0);
    send(1'b0, 8, 0);
    send(1'b0, 8191 & 4095, 0);
    send(1'b1, 0, 0);
    send(1'b1, 0, 4095);
    send(1'b1, 8191 & 4096, 11);
    send(1'b1, 0, 12);
    send(1'b1, 0, 12);
    send(1'b1, 0, 20);
    send(1'b1, 0, 28);
    send(1'b0, 12, 0);
    drain();
    set_arena(16);
    send(1'b0, 0, 0);
    send(1'b0, 0, 0);
    send(1'b1, 0, 12);
    send(1'b0, 5, 0);
    set_arena(0);
    send(1'b0, 4, 0);
    set_arena(8191);
    send(1'b0, 4084, 0);
    send(1'b1, 0, 12);

    set_arena(4096);
    random_items(300, 6);
    set_arena(64);
    random_items(150, 30);
    set_arena($urandom_range(16, 4096));
    random_items(250, 10);
    set_arena(200);
    random_items(200, 20);
    set_arena(4095);
    random_items(250, 4);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
